// File: design/fnip_pkg.sv
// ============================================================================
// fnip_pkg
// Shared types and constants of the free node id picker: id widths, the
// register indexes of the configuration port, the controller states and the
// structs that run between the controller and the bitmap cells.
// ============================================================================
`default_nettype none

package fnip_pkg;

    // Node ids are 7 bits wide; the seen-id bitmap is kept in 32-bit words.
    localparam int ID_W       = 7;
    localparam int WORD_W     = 32;
    localparam int BIT_SEL_W  = 5;
    localparam int WORD_SEL_W = ID_W - BIT_SEL_W;

    // Id reported when no free id is left, and the first usable id.
    localparam logic [ID_W-1:0] ID_NONE_FREE = 7'd126;
    localparam logic [ID_W-1:0] ID_FIRST     = 7'd1;

    // Reset values of the configuration registers.
    localparam logic [ID_W-1:0] START_ID_RST  = 7'd1;
    localparam logic [31:0]     CLEAR_INT_RST = 32'd1000000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_START_ID  = 1'b0,
        REG_CLEAR_INT = 1'b1
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Bitmap update command broadcast to every cell.
    typedef struct packed {
        logic            clear;
        logic            mark;
        logic [ID_W-1:0] mark_id;
    } cell_cmd_t;

    // Search bounds broadcast to every cell: the upward pass covers
    // lo_a..MAX_ID, the wrap pass covers 1..hi_b.
    typedef struct packed {
        logic [ID_W-1:0] lo_a;
        logic [ID_W-1:0] hi_b;
    } scan_ctl_t;

    // Running search result handed from cell to cell.
    typedef struct packed {
        logic            found_a;
        logic [ID_W-1:0] id_a;
        logic            found_b;
        logic [ID_W-1:0] id_b;
    } token_t;

endpackage

`default_nettype wire

// File: design/fnip_cell.sv
// ============================================================================
// fnip_cell
// One cell of the seen-id bitmap. It holds one 32-bit word of the map,
// applies clear and mark commands, and each cycle merges its own lowest free
// ids into the search word coming from the previous cell.
// ============================================================================
`default_nettype none

module fnip_cell #(
    parameter int IDX    = 0,
    parameter int MAX_ID = 125
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fnip_pkg::cell_cmd_t cmd,
    input  wire fnip_pkg::scan_ctl_t scan,
    input  wire fnip_pkg::token_t    chain_in,
    output fnip_pkg::token_t         chain_out
);

    // Id held by bit 0 of this word.
    localparam logic [fnip_pkg::ID_W-1:0] BASE_ID =
        fnip_pkg::ID_W'(IDX * fnip_pkg::WORD_W + 1);

    logic [fnip_pkg::WORD_W-1:0]     map_reg;
    logic [fnip_pkg::WORD_W-1:0]     map_next;
    logic [fnip_pkg::ID_W-1:0]       mark_m1;
    fnip_pkg::token_t                local_tok;
    fnip_pkg::token_t                chain_next;
    fnip_pkg::token_t                chain_reg;

    // Clear first, then mark the received id if it falls in this word.
    assign mark_m1 = cmd.mark_id - fnip_pkg::ID_FIRST;

    always_comb
    begin
        map_next = cmd.clear ? '0 : map_reg;
        if (cmd.mark &&
            (mark_m1[fnip_pkg::ID_W-1:fnip_pkg::BIT_SEL_W] ==
             fnip_pkg::WORD_SEL_W'(IDX)))
        begin
            map_next[mark_m1[fnip_pkg::BIT_SEL_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    // Lowest free id of this word inside each search range. Bits beyond
    // MAX_ID never count as free.
    always_comb
    begin
        logic [fnip_pkg::ID_W-1:0] bit_id;
        local_tok = '0;
        bit_id    = '0;
        for (int b = fnip_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if ((IDX * fnip_pkg::WORD_W + b + 1) <= MAX_ID)
            begin
                bit_id = BASE_ID + fnip_pkg::ID_W'(b);
                if (!map_reg[b] && (bit_id >= scan.lo_a))
                begin
                    local_tok.found_a = 1'b1;
                    local_tok.id_a    = bit_id;
                end
                if (!map_reg[b] && (bit_id <= scan.hi_b))
                begin
                    local_tok.found_b = 1'b1;
                    local_tok.id_b    = bit_id;
                end
            end
        end
    end

    // A hit from a lower word always wins over this word.
    always_comb
    begin
        chain_next.found_a = chain_in.found_a | local_tok.found_a;
        chain_next.id_a    = chain_in.found_a ? chain_in.id_a : local_tok.id_a;
        chain_next.found_b = chain_in.found_b | local_tok.found_b;
        chain_next.id_b    = chain_in.found_b ? chain_in.id_b : local_tok.id_b;
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
    end

    assign chain_out = chain_reg;

endmodule

`default_nettype wire

// File: design/free_node_id_picker.sv
// ============================================================================
// free_node_id_picker
// Tracks the node ids seen on the bus and picks the first free one for this
// node, clearing the seen-id map at a programmable interval.
// ============================================================================
// One word in gives one word out. An accepted call is taken in ST_IDLE,
// clears and marks the bitmap in ST_UPDATE, and then in ST_SCAN the search
// word walks down the row of NCELLS = ceil(MAX_ID / 32) bitmap cells, one
// cell per cycle; ST_DONE then loads its result into the output register,
// waiting while that register is full and not being drained. A call without
// a frame skips the walk. A new call is taken only while the controller is
// idle; a finished result waiting in the output register does not stop the
// next call from being accepted. Configuration writes are taken in every
// cycle and must be issued only while the block is idle; a write of
// start_node_id also loads the current id.
`default_nettype none

module free_node_id_picker #(
    parameter int MAX_ID = 125
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] time_us, [38:32] frame_src_id
    input  wire logic        s_axis_tuser,  // [0] frame_seen
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [6:0] own_id
    output logic [1:0]       m_axis_tuser   // [0] id_changed, [1] map_cleared
);

    localparam int NCELLS = (MAX_ID + fnip_pkg::WORD_W - 1) / fnip_pkg::WORD_W;
    localparam int CNT_W  = $clog2(NCELLS + 1);
    localparam logic [fnip_pkg::ID_W-1:0] MAX_ID_V = fnip_pkg::ID_W'(MAX_ID);

    fnip_pkg::state_t            state_reg;
    fnip_pkg::state_t            state_next;

    logic [31:0]                 time_reg;
    logic                        frame_reg;
    logic [fnip_pkg::ID_W-1:0]   src_reg;
    logic [fnip_pkg::ID_W-1:0]   before_reg;
    logic [fnip_pkg::ID_W-1:0]   cur_id_reg;
    logic [31:0]                 last_clear_reg;
    logic [31:0]                 clear_int_reg;
    logic                        cleared_reg;
    logic [CNT_W-1:0]            scan_cnt_reg;

    logic                        out_valid_reg;
    logic [fnip_pkg::ID_W-1:0]   out_id_reg;
    logic                        out_chg_reg;
    logic                        out_clr_reg;

    logic                        in_fire;
    logic                        out_free;
    logic                        clear_hit;
    logic                        mark_en;
    logic                        scan_last;
    logic [31:0]                 elapsed;
    logic [fnip_pkg::ID_W-1:0]   picked_id;

    fnip_pkg::cell_cmd_t         cell_cmd;
    fnip_pkg::scan_ctl_t         scan_ctl;
    fnip_pkg::token_t            chain [0:NCELLS];

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    // Clear check: wrapping time since the last clear against the interval.
    assign elapsed   = time_reg - last_clear_reg;
    assign clear_hit = (elapsed >= clear_int_reg);

    // Only ids 1..MAX_ID of a received frame are recorded.
    assign mark_en = frame_reg && (src_reg != '0) && (src_reg <= MAX_ID_V);

    assign scan_last = (scan_cnt_reg == CNT_W'(NCELLS));

    // Search bounds from the current id.
    always_comb
    begin
        scan_ctl.lo_a = (cur_id_reg == '0) ? fnip_pkg::ID_FIRST : cur_id_reg;
        scan_ctl.hi_b = (cur_id_reg > MAX_ID_V) ? MAX_ID_V : cur_id_reg;
    end

    // Result of the search leaving the last cell.
    always_comb
    begin
        if (chain[NCELLS].found_a)
        begin
            picked_id = chain[NCELLS].id_a;
        end
        else if (chain[NCELLS].found_b)
        begin
            picked_id = chain[NCELLS].id_b;
        end
        else
        begin
            picked_id = fnip_pkg::ID_NONE_FREE;
        end
    end

    // Row of bitmap cells; the search word enters empty at cell 0.
    assign chain[0] = '0;

    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        fnip_cell #(
            .IDX    (k),
            .MAX_ID (MAX_ID)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd),
            .scan      (scan_ctl),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fnip_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = fnip_pkg::ST_UPDATE;
                end
            end
            fnip_pkg::ST_UPDATE:
            begin
                state_next = frame_reg ? fnip_pkg::ST_SCAN : fnip_pkg::ST_DONE;
            end
            fnip_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = fnip_pkg::ST_DONE;
                end
            end
            fnip_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fnip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fnip_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready    = 1'b0;
        cell_cmd.clear   = 1'b0;
        cell_cmd.mark    = 1'b0;
        cell_cmd.mark_id = src_reg;
        unique case (state_reg)
            fnip_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            fnip_pkg::ST_UPDATE:
            begin
                cell_cmd.clear = clear_hit;
                cell_cmd.mark  = mark_en;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fnip_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            time_reg  <= s_axis_tdata[31:0];
            src_reg   <= s_axis_tdata[38:32];
            frame_reg <= s_axis_tuser;
        end
    end

    // Node state, configuration registers and the search counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_id_reg     <= fnip_pkg::START_ID_RST;
            before_reg     <= fnip_pkg::START_ID_RST;
            last_clear_reg <= '0;
            clear_int_reg  <= fnip_pkg::CLEAR_INT_RST;
            cleared_reg    <= 1'b0;
            scan_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    fnip_pkg::REG_START_ID:
                    begin
                        cur_id_reg <= cfg_data[fnip_pkg::ID_W-1:0];
                    end
                    fnip_pkg::REG_CLEAR_INT:
                    begin
                        clear_int_reg <= cfg_data;
                    end
                    default:
                    begin
                        clear_int_reg <= clear_int_reg;
                    end
                endcase
            end

            if (in_fire)
            begin
                before_reg <= cur_id_reg;
            end

            if (state_reg == fnip_pkg::ST_UPDATE)
            begin
                cleared_reg  <= clear_hit;
                scan_cnt_reg <= '0;
                if (clear_hit)
                begin
                    last_clear_reg <= time_reg;
                    if (cur_id_reg == fnip_pkg::ID_NONE_FREE)
                    begin
                        cur_id_reg <= fnip_pkg::ID_FIRST;
                    end
                end
            end

            if (state_reg == fnip_pkg::ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (scan_last)
                begin
                    cur_id_reg <= picked_id;
                end
            end
        end
    end

    // Output register; it is loaded in ST_DONE when it is empty or being drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == fnip_pkg::ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fnip_pkg::ST_DONE && out_free)
        begin
            out_id_reg  <= cur_id_reg;
            out_chg_reg <= (cur_id_reg != before_reg);
            out_clr_reg <= cleared_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_id_reg};
    assign m_axis_tuser  = {out_clr_reg, out_chg_reg};

endmodule

`default_nettype wire
